// ===== src/lpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpsd_pkg
// Shared types and constants of the length-prefixed string deframer.
// ----------------------------------------------------------------------------
package lpsd_pkg;

  localparam int unsigned MaxLenW = 16;
  localparam int unsigned LenW    = 32;

  localparam logic [MaxLenW-1:0] MaxLenReset = 16'd256;

  localparam logic [7:0] PrefixLen16 = 8'd253;
  localparam logic [7:0] PrefixLen32 = 8'd254;
  localparam logic [7:0] PrefixLen64 = 8'd255;

  typedef enum logic [1:0] {
    KindByte  = 2'd0,
    KindDone  = 2'd1,
    KindError = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        payload_byte;
    logic              string_end;
    logic [LenW-1:0]   declared_length;
  } result_t;

endpackage

// ===== src/lpsd_step.sv =====
// ----------------------------------------------------------------------------
// lpsd_step
// Deframing state and its combinational next-state update for one input transaction.
// ----------------------------------------------------------------------------
module lpsd_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lpsd_pkg::MaxLenW-1:0]  max_len_i,
  input  logic                          en_i,
  input  logic                          func_i,
  input  logic [7:0]                    data_byte_i,
  output logic                          res_valid_o,
  output lpsd_pkg::result_t             res_o
);

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhPrefix  = 2'd1,
    PhPayload = 2'd2
  } phase_e;

  phase_e                         phase_q, phase_d;
  logic [3:0]                     left_q, left_d;
  logic [2:0]                     idx_q, idx_d;
  logic [lpsd_pkg::LenW-1:0]      acc_q, acc_d;
  logic [lpsd_pkg::LenW-1:0]      rem_q, rem_d;
  logic [lpsd_pkg::MaxLenW-1:0]   pos_q, pos_d;

  logic [lpsd_pkg::MaxLenW-1:0]   limit;
  logic                           start;
  logic [lpsd_pkg::LenW-1:0]      start_len;
  logic                           keep;
  logic                           last;

  always_comb begin
    phase_d     = phase_q;
    left_d      = left_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    pos_d       = pos_q;
    start       = 1'b0;
    start_len   = '0;
    keep        = 1'b0;
    last        = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{kind: lpsd_pkg::KindDone, payload_byte: 8'd0, string_end: 1'b0,
                    declared_length: '0};
    limit       = (max_len_i == '0) ? '0 : max_len_i - 1'b1;

    if (en_i) begin
      if (func_i) begin
        if (phase_q == PhPrefix || phase_q == PhPayload) begin
          phase_d     = PhIdle;
          left_d      = '0;
          idx_d       = '0;
          rem_d       = '0;
          pos_d       = '0;
          res_valid_o = 1'b1;
          res_o.kind  = lpsd_pkg::KindError;
        end
      end else begin
        case (phase_q)
          PhPrefix: begin
            if (!idx_q[2]) begin
              acc_d = acc_q | ({24'd0, data_byte_i} << {idx_q[1:0], 3'b000});
            end
            idx_d  = idx_q + 3'd1;
            left_d = left_q - 4'd1;
            if (left_d == 4'd0) begin
              idx_d     = '0;
              start     = 1'b1;
              start_len = acc_d;
            end
          end
          PhPayload: begin
            keep  = pos_q < limit;
            last  = rem_q == 32'd1;
            pos_d = (pos_q == '1) ? pos_q : pos_q + 1'b1;
            rem_d = rem_q - 32'd1;
            if (last) begin
              phase_d = PhIdle;
            end
            if (keep) begin
              res_valid_o           = 1'b1;
              res_o.kind            = lpsd_pkg::KindByte;
              res_o.payload_byte    = data_byte_i;
              res_o.string_end      = last;
              res_o.declared_length = last ? acc_q : '0;
            end else if (last) begin
              res_valid_o           = 1'b1;
              res_o.kind            = lpsd_pkg::KindDone;
              res_o.string_end      = 1'b1;
              res_o.declared_length = acc_q;
            end
          end
          default: begin
            acc_d = '0;
            idx_d = '0;
            if (data_byte_i < lpsd_pkg::PrefixLen16) begin
              start     = 1'b1;
              start_len = {24'd0, data_byte_i};
              acc_d     = start_len;
            end else begin
              if (data_byte_i == lpsd_pkg::PrefixLen16) begin
                left_d = 4'd2;
              end else if (data_byte_i == lpsd_pkg::PrefixLen32) begin
                left_d = 4'd4;
              end else begin
                left_d = 4'd8;
              end
              phase_d = PhPrefix;
            end
          end
        endcase

        if (start) begin
          if (start_len == '0) begin
            phase_d          = PhIdle;
            res_valid_o      = 1'b1;
            res_o.kind       = lpsd_pkg::KindDone;
            res_o.string_end = 1'b1;
          end else begin
            phase_d = PhPayload;
            rem_d   = start_len;
            pos_d   = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      left_q  <= '0;
      idx_q   <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
    end
  end

  // An end of buffer between strings never produces a result.
  a_idle_eob_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && func_i && phase_q == PhIdle) |-> !res_valid_o)
    else $error("result produced for end of buffer between strings");

  // While in the payload phase at least one payload byte is still expected.
  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPayload) |-> (rem_q != '0))
    else $error("payload phase with no bytes remaining");

  // A string that ends returns the deframer to idle.
  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.string_end) |=> (phase_q == PhIdle))
    else $error("string ended without returning to idle");

endmodule

// ===== src/lpsd_out_buf.sv =====
// ----------------------------------------------------------------------------
// lpsd_out_buf
// Two-entry result buffer that decouples the output stall from the core.
// ----------------------------------------------------------------------------
module lpsd_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lpsd_pkg::result_t  push_data_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               stall_i,
  output lpsd_pkg::result_t  data_o
);

  lpsd_pkg::result_t  mem_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q, cnt_d;
  logic               pop;

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

endmodule

// ===== src/length_prefixed_string_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_string_deframer_unit
// Splits a byte stream of count-prefixed strings into delivered string bytes, end-of-string and error results.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o | func_i, data_byte_i
//  out     | output    | out_valid_o / out_stall_i| kind_o, payload_byte_o,
//          |           |                        | string_end_o, declared_length_o
//  cfg     | input     | cfg_we_i               | cfg_wdata_i (max_len)
//
// One transaction is accepted per cycle while in_stall_o is low; it is captured
// in the input register and processed by the step logic; any result it produces
// is written into the two-entry result buffer, from which it is presented.
// Reset returns the deframer to idle and sets max_len to 256.
// The input stalls only when the result buffer is full and an item is waiting.
// ----------------------------------------------------------------------------
module length_prefixed_string_deframer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpsd_pkg::MaxLenW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic [7:0]                    payload_byte_o,
  output logic                          string_end_o,
  output logic [lpsd_pkg::LenW-1:0]     declared_length_o
);

  logic [lpsd_pkg::MaxLenW-1:0]  max_len_q;
  logic                          in_valid_q;
  logic                          func_q;
  logic [7:0]                    data_byte_q;
  logic                          buf_full;
  logic                          advance;
  logic                          res_valid;
  lpsd_pkg::result_t             res;
  lpsd_pkg::result_t             out_res;

  assign in_stall_o = in_valid_q && buf_full;
  assign advance    = in_valid_q && !buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q  <= lpsd_pkg::MaxLenReset;
      in_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      func_q      <= func_i;
      data_byte_q <= data_byte_i;
    end
  end

  lpsd_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_len_i   (max_len_q),
    .en_i        (advance),
    .func_i      (func_q),
    .data_byte_i (data_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lpsd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .data_o      (out_res)
  );

  assign kind_o            = out_res.kind;
  assign payload_byte_o    = out_res.payload_byte;
  assign string_end_o      = out_res.string_end;
  assign declared_length_o = out_res.declared_length;

endmodule
